>>> rtl/q2e_pkg.sv
// Package for the quaternion to Euler angle converter.
// Types and constants shared by the CORDIC cells, root cells and the top level.
package q2e_pkg;

  localparam int unsigned CordicSteps = 20;
  localparam int unsigned VecW = 44;   // CORDIC datapath width (signed)
  localparam int unsigned AccW = 26;   // angle accumulator, 2^-16 degree units
  localparam int unsigned RootSteps = 30;
  localparam int unsigned RootW = 62;  // remainder width of square root
  localparam logic signed [AccW-1:0] QuarterAcc = 26'sd5898240;
  localparam logic signed [15:0] HalfTurn = 16'sd23040;
  localparam logic signed [14:0] QuarterTurn = 15'sd11520;

  typedef struct packed {
    logic signed [VecW-1:0] x;
    logic signed [VecW-1:0] y;
    logic signed [AccW-1:0] acc;
    logic                   zero;
  } cordic_t;

  typedef struct packed {
    logic [RootW-1:0] rem;
    logic [31:0]      root;
  } root_t;

  function automatic logic signed [AccW-1:0] step_angle(input logic [4:0] i);
    case (i)
      5'd0:  step_angle = 26'sd2949120;
      5'd1:  step_angle = 26'sd1740967;
      5'd2:  step_angle = 26'sd919879;
      5'd3:  step_angle = 26'sd466945;
      5'd4:  step_angle = 26'sd234379;
      5'd5:  step_angle = 26'sd117304;
      5'd6:  step_angle = 26'sd58666;
      5'd7:  step_angle = 26'sd29335;
      5'd8:  step_angle = 26'sd14668;
      5'd9:  step_angle = 26'sd7334;
      5'd10: step_angle = 26'sd3667;
      5'd11: step_angle = 26'sd1833;
      5'd12: step_angle = 26'sd917;
      5'd13: step_angle = 26'sd458;
      5'd14: step_angle = 26'sd229;
      5'd15: step_angle = 26'sd115;
      5'd16: step_angle = 26'sd57;
      5'd17: step_angle = 26'sd29;
      5'd18: step_angle = 26'sd14;
      5'd19: step_angle = 26'sd7;
      default: step_angle = '0;
    endcase
  endfunction

endpackage

>>> rtl/q2e_cordic_cell.sv
// One vectoring CORDIC rotation step, registered.
// Depends on q2e_pkg.
module q2e_cordic_cell #(
  parameter int unsigned Step = 0
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  q2e_pkg::cordic_t in_i,
  output q2e_pkg::cordic_t out_o
);
  import q2e_pkg::*;

  cordic_t cell_d, cell_q;

  always_comb begin
    cell_d = in_i;
    if (!in_i.y[VecW-1]) begin
      cell_d.x   = in_i.x + (in_i.y >>> Step);
      cell_d.y   = in_i.y - (in_i.x >>> Step);
      cell_d.acc = in_i.acc + step_angle(5'(Step));
    end else begin
      cell_d.x   = in_i.x - (in_i.y >>> Step);
      cell_d.y   = in_i.y + (in_i.x >>> Step);
      cell_d.acc = in_i.acc - step_angle(5'(Step));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) cell_q <= cell_d;
  end

  assign out_o = cell_q;
endmodule

>>> rtl/q2e_root_cell.sv
// One bit of a restoring square root, registered; carries a side payload.
// Depends on q2e_pkg.
module q2e_root_cell #(
  parameter int unsigned Step = 0,
  parameter int unsigned SideW = 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  q2e_pkg::root_t   in_i,
  input  logic [SideW-1:0] side_i,
  output q2e_pkg::root_t   out_o,
  output logic [SideW-1:0] side_o
);
  import q2e_pkg::*;

  root_t             cell_d, cell_q;
  logic [SideW-1:0]  side_q;
  logic [RootW+1:0]  trial;
  logic [RootW+1:0]  rem_ext;

  // root digit k = RootSteps-1-Step; trial = (4*root+1) << 2k
  always_comb begin
    rem_ext = {2'b00, in_i.rem};
    trial   = ({{(RootW-32){1'b0}}, in_i.root, 2'b01})
              << (2 * (RootSteps - 1 - Step));
    cell_d  = in_i;
    if (rem_ext >= trial) begin
      cell_d.rem  = RootW'(rem_ext - trial);
      cell_d.root = {in_i.root[30:0], 1'b1};
    end else begin
      cell_d.root = {in_i.root[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
      side_q <= side_i;
    end
  end

  assign out_o  = cell_q;
  assign side_o = side_q;
endmodule

>>> rtl/q2e_atan_chain.sv
// atan2 front end (half-plane fold, normalise) plus a row of CORDIC cells.
// Depends on q2e_pkg and q2e_cordic_cell.
module q2e_atan_chain (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic signed [q2e_pkg::VecW-1:0] y_i,
  input  logic signed [q2e_pkg::VecW-1:0] x_i,
  output logic signed [15:0]              angle_o
);
  import q2e_pkg::*;

  cordic_t fold_d, fold_q, norm_d, norm_q;
  cordic_t link [CordicSteps+1];
  logic [VecW-1:0] mx, my, mm;
  logic signed [AccW-1:0] rnd;
  logic signed [AccW-10:0] ang;

  always_comb begin
    fold_d.x = x_i;
    fold_d.y = y_i;
    fold_d.acc = '0;
    fold_d.zero = (x_i == '0) && (y_i == '0);
    if (x_i[VecW-1]) begin
      if (!y_i[VecW-1]) begin
        fold_d.x = y_i; fold_d.y = -x_i; fold_d.acc = QuarterAcc;
      end else begin
        fold_d.x = -y_i; fold_d.y = x_i; fold_d.acc = -QuarterAcc;
      end
    end
  end

  // Shift left so the larger magnitude reaches bit 40 (inputs below 2^35+1).
  always_comb begin
    mx = fold_q.x[VecW-1] ? -fold_q.x : fold_q.x;
    my = fold_q.y[VecW-1] ? -fold_q.y : fold_q.y;
    mm = (mx > my) ? mx : my;
    norm_d = fold_q;
    for (int k = 40; k >= 1; k--) begin
      if (mm[k]) break;
      norm_d.x = norm_d.x <<< 1;
      norm_d.y = norm_d.y <<< 1;
    end
    if (fold_q.zero) begin
      norm_d.x = '0; norm_d.y = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fold_q <= fold_d;
      norm_q <= norm_d;
    end
  end

  assign link[0] = norm_q;
  for (genvar g = 0; g < CordicSteps; g++) begin : g_cell
    q2e_cordic_cell #(.Step(g)) u_cell (
      .clk_i(clk_i), .en_i(en_i), .in_i(link[g]), .out_o(link[g+1])
    );
  end

  always_comb begin
    rnd = link[CordicSteps].acc + AccW'(256);
    ang = rnd[AccW-1:9];
    if (link[CordicSteps].zero) angle_o = '0;
    else if (ang > (AccW-9)'(23040)) angle_o = HalfTurn;
    else if (ang < -(AccW-9)'(23040)) angle_o = -HalfTurn;
    else angle_o = ang[15:0];
  end
endmodule

>>> rtl/quaternion_to_euler_core.sv
// Quaternion to roll/pitch/yaw, fully pipelined: one item per cycle except
// during a stall. Stages: a product stage and a sum stage, 30 root cells,
// 2 fold/normalise stages and 20 CORDIC cells, then an output register. The
// whole pipe stalls while the output register is full and
// not taken. Reset clears only the valid bits; data registers are not reset.
module quaternion_to_euler_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] quat_w_i,
  input  logic signed [15:0] quat_x_i,
  input  logic signed [15:0] quat_y_i,
  input  logic signed [15:0] quat_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] roll_angle_o,
  output logic signed [14:0] pitch_angle_o,
  output logic signed [15:0] yaw_angle_o,
  output logic               pitch_clamped_o
);
  import q2e_pkg::*;

  localparam int unsigned Depth = 2 + RootSteps + 2 + CordicSteps;
  localparam int unsigned SideW = 3 * 35 + 2;

  logic en;
  logic [Depth-1:0] vld_q;
  logic out_vld_q;

  // stage 1: products
  logic signed [31:0] wx_q, yz_q, xx_q, yy_q, wy_q, zx_q, wz_q, xy_q, zz_q;
  // stage 2: sums in Q.30 with guard bits
  logic signed [34:0] ry_q, rx_q, yy2_q, yx_q, s_q;
  logic signed [34:0] ry_d, rx_d, yy2_d, yx_d, s_d;
  logic [RootW-1:0] rest;
  logic sneg, sbig;

  root_t rlink [RootSteps+1];
  logic [SideW-1:0] slink [RootSteps+1];

  logic signed [34:0] ry_r, rx_r, yy_r, yx_r, s_r;
  logic big_r;
  logic signed [VecW-1:0] px;
  logic signed [15:0] roll_a, pitch_a, yaw_a;
  logic [CordicSteps+1:0] big_sh_q, neg_sh_q;
  logic big_d2, neg_d2;
  logic signed [15:0] roll_q, yaw_q;
  logic signed [14:0] pitch_q;
  logic clamp_q;

  assign en = !out_vld_q || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-2:0], in_valid_i};
      out_vld_q <= vld_q[Depth-1];
    end
  end
  assign out_valid_o = out_vld_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      wx_q <= quat_w_i * quat_x_i; yz_q <= quat_y_i * quat_z_i;
      xx_q <= quat_x_i * quat_x_i; yy_q <= quat_y_i * quat_y_i;
      wy_q <= quat_w_i * quat_y_i; zx_q <= quat_z_i * quat_x_i;
      wz_q <= quat_w_i * quat_z_i; xy_q <= quat_x_i * quat_y_i;
      zz_q <= quat_z_i * quat_z_i;
    end
  end

  always_comb begin
    ry_d  = 35'(wx_q) + 35'(yz_q); ry_d = ry_d <<< 1;
    rx_d  = 35'sd1073741824 - ((35'(xx_q) + 35'(yy_q)) <<< 1);
    yx_d  = 35'sd1073741824 - ((35'(yy_q) + 35'(zz_q)) <<< 1);
    yy2_d = (35'(wz_q) + 35'(xy_q)) <<< 1;
    s_d   = (35'(wy_q) - 35'(zx_q)) <<< 1;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ry_q <= ry_d; rx_q <= rx_d; yy2_q <= yy2_d; yx_q <= yx_d; s_q <= s_d;
    end
  end

  // 2^60 - s^2 for |s| < 2^30; clamp case feeds a dummy value
  always_comb begin
    logic [29:0] sm;
    logic [34:0] sa;
    sa   = s_q[34] ? 35'(-s_q) : 35'(s_q);
    sneg = s_q[34];
    sbig = sa >= 35'd1073741824;
    sm   = sa[29:0];
    rest = sbig ? '0 : RootW'((61'd1 << 60) - 61'(60'(sm) * 60'(sm)));
  end

  assign rlink[0] = '{rem: rest, root: '0};
  assign slink[0] = {ry_q, rx_q, s_q, sbig, sneg};
  for (genvar g = 0; g < RootSteps; g++) begin : g_root
    q2e_root_cell #(.Step(g), .SideW(SideW)) u_root (
      .clk_i(clk_i), .en_i(en), .in_i(rlink[g]), .side_i(slink[g]),
      .out_o(rlink[g+1]), .side_o(slink[g+1])
    );
  end

  // yaw operands ride along beside the root chain
  logic signed [34:0] yy_line [RootSteps];
  logic signed [34:0] yx_line [RootSteps];
  always_ff @(posedge clk_i) begin
    if (en) begin
      yy_line[0] <= yy2_q;
      yx_line[0] <= yx_q;
      for (int k = 1; k < RootSteps; k++) begin
        yy_line[k] <= yy_line[k-1];
        yx_line[k] <= yx_line[k-1];
      end
    end
  end

  assign {ry_r, rx_r, s_r, big_r, neg_d2} = slink[RootSteps];
  assign yy_r = yy_line[RootSteps-1];
  assign yx_r = yx_line[RootSteps-1];
  assign big_d2 = big_r;
  assign px = VecW'(rlink[RootSteps].root);

  q2e_atan_chain u_roll (.clk_i(clk_i), .en_i(en), .y_i(VecW'(ry_r)),
                         .x_i(VecW'(rx_r)), .angle_o(roll_a));
  q2e_atan_chain u_pitch (.clk_i(clk_i), .en_i(en), .y_i(VecW'(s_r)),
                          .x_i(px), .angle_o(pitch_a));
  q2e_atan_chain u_yaw (.clk_i(clk_i), .en_i(en), .y_i(VecW'(yy_r)),
                        .x_i(VecW'(yx_r)), .angle_o(yaw_a));

  always_ff @(posedge clk_i) begin
    if (en) begin
      big_sh_q <= {big_sh_q[CordicSteps:0], big_d2};
      neg_sh_q <= {neg_sh_q[CordicSteps:0], neg_d2};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      roll_q  <= roll_a;
      yaw_q   <= yaw_a;
      clamp_q <= big_sh_q[CordicSteps+1];
      if (big_sh_q[CordicSteps+1])
        pitch_q <= neg_sh_q[CordicSteps+1] ? -QuarterTurn : QuarterTurn;
      else if (pitch_a > 16'(QuarterTurn)) pitch_q <= QuarterTurn;
      else if (pitch_a < -16'(QuarterTurn)) pitch_q <= -QuarterTurn;
      else pitch_q <= pitch_a[14:0];
    end
  end

  assign roll_angle_o    = roll_q;
  assign pitch_angle_o   = pitch_q;
  assign yaw_angle_o     = yaw_q;
  assign pitch_clamped_o = clamp_q;
endmodule

>>> test/tb_quaternion_to_euler_core.sv
// Testbench for quaternion_to_euler_core: random and corner quaternions with
// random stalls on both handshakes, checked against a bit-exact angle predictor.
// Depends on rtl/q2e_pkg.sv and rtl/quaternion_to_euler_core.sv.

typedef struct packed {
  logic signed [15:0] roll;
  logic signed [14:0] pitch;
  logic signed [15:0] yaw;
  logic               clamped;
} euler_t;

class euler_scoreboard;
  euler_t pending_q[$];
  int     mismatches;

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint isqrt(longint v);
    longint r, b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic longint atan_units(longint y, longint x);
    longint acc, t, m, dx, dy, ax, ay;
    acc = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = y; y = -x; x = t; acc = 90 * 65536;
      end else begin
        t = -y; y = x; x = t; acc = -90 * 65536;
      end
    end
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    m = (ax > ay) ? ax : ay;
    while (m < (64'sd1 <<< 40)) begin
      x = x * 2; y = y * 2; m = m * 2;
    end
    for (int i = 0; i < q2e_pkg::CordicSteps; i++) begin
      dx = shr_floor(y, i);
      dy = shr_floor(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; acc += longint'(q2e_pkg::step_angle(5'(i)));
      end else begin
        x -= dx; y += dy; acc -= longint'(q2e_pkg::step_angle(5'(i)));
      end
    end
    t = shr_floor(acc + 256, 9);
    if (t > 23040) t = 23040;
    if (t < -23040) t = -23040;
    return t;
  endfunction

  function automatic euler_t to_euler(longint w, longint x, longint y, longint z);
    euler_t e;
    longint one, s, p;
    one = 64'sd1 <<< 30;
    e.roll = 16'(atan_units(2 * (w * x + y * z), one - 2 * (x * x + y * y)));
    s = 2 * (w * y - z * x);
    e.clamped = 1'b0;
    if (s >= one || -s >= one) begin
      p = (s < 0) ? -11520 : 11520;
      e.clamped = 1'b1;
    end else begin
      p = atan_units(s, isqrt((64'sd1 <<< 60) - s * s));
      if (p > 11520) p = 11520;
      if (p < -11520) p = -11520;
    end
    e.pitch = 15'(p);
    e.yaw = 16'(atan_units(2 * (w * z + x * y), one - 2 * (y * y + z * z)));
    return e;
  endfunction

  function void note_quat(logic signed [15:0] w, x, y, z);
    pending_q.insert(pending_q.size(), to_euler(w, x, y, z));
  endfunction

  function void check_angles(euler_t got);
    euler_t exp_e;
    if (pending_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %p", got);
      return;
    end
    exp_e = pending_q.pop_front();
    if (got !== exp_e) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: exp r=%0d p=%0d y=%0d c=%0d got r=%0d p=%0d y=%0d c=%0d",
                 exp_e.roll, exp_e.pitch, exp_e.yaw, exp_e.clamped,
                 got.roll, got.pitch, got.yaw, got.clamped);
    end
  endfunction
endclass

module tb_quaternion_to_euler_core;
  localparam int NumRandom = 900;
  localparam int Latency = 55;
  localparam longint CycleLimit = 200000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic out_ready_i = 1'b0;
  logic signed [15:0] quat_w_i = '0, quat_x_i = '0, quat_y_i = '0, quat_z_i = '0;
  logic in_ready_o, out_valid_o, pitch_clamped_o;
  logic signed [15:0] roll_angle_o, yaw_angle_o;
  logic signed [14:0] pitch_angle_o;

  euler_scoreboard angle_sb = new();
  bit      quiet_phase = 1'b0;
  bit      sink_hold = 1'b0;
  longint  cycle_count = 0;

  quaternion_to_euler_core i_dut (.*);

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("** quaternion_to_euler_core: FAILED **");
      $finish;
    end
    if (rst_ni && in_valid_i && in_ready_o)
      angle_sb.note_quat(quat_w_i, quat_x_i, quat_y_i, quat_z_i);
    if (rst_ni && out_valid_o && out_ready_i)
      angle_sb.check_angles({roll_angle_o, pitch_angle_o, yaw_angle_o, pitch_clamped_o});
  end

  // receiver: random bursts of stall, or a long hold when asked
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (sink_hold) begin
        out_ready_i <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        n = $urandom_range(1, 8);
        repeat (n - 1) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    @(posedge rst_ni);
    repeat (20) @(negedge clk_i);
    sink_hold = 1'b1;
    repeat (300) @(negedge clk_i);
    sink_hold = 1'b0;
  end

  // hold valid across back-to-back items; drop it only for an idle burst
  task automatic send_quat(logic signed [15:0] w, x, y, z);
    int n;
    if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 8);
      in_valid_i <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    quat_w_i <= w; quat_x_i <= x; quat_y_i <= y; quat_z_i <= z;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  function automatic logic signed [15:0] rand_comp(int unit_ish);
    if (unit_ish != 0) return 16'($signed($urandom_range(0, 46340)) - 23170);
    return 16'($urandom);
  endfunction

  initial begin
    logic signed [15:0] corner [6];
    corner = '{16'sh7fff, -16'sh8000, 16'sh0000, 16'sh0001, -16'sh0001, 16'sh5a82};
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // directed: identity, axis turns, extremes, gimbal lock, zero quaternion
    send_quat(16'sh7fff, '0, '0, '0);
    send_quat('0, '0, '0, '0);
    send_quat('0, 16'sh7fff, '0, '0);
    send_quat('0, '0, 16'sh7fff, '0);
    send_quat('0, '0, '0, 16'sh7fff);
    send_quat(16'sh5a82, '0, 16'sh5a82, '0);
    send_quat(16'sh5a82, '0, -16'sh5a82, '0);
    send_quat(-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000);
    send_quat(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_quat(16'sh7fff, -16'sh8000, 16'sh7fff, -16'sh8000);
    send_quat('0, -16'sh8000, '0, '0);
    send_quat(16'sh4000, 16'sh4000, 16'sh4000, 16'sh4000);
    send_quat(16'sh4000, -16'sh4000, 16'sh4000, 16'sh4000);
    for (int i = 0; i < 10; i++)
      send_quat(corner[$urandom_range(0, 5)], corner[$urandom_range(0, 5)],
                corner[$urandom_range(0, 5)], corner[$urandom_range(0, 5)]);
    for (int i = 0; i < NumRandom; i++) begin
      int u;
      if (i > NumRandom - 100) quiet_phase = 1'b1;
      u = ($urandom_range(0, 3) != 0);
      send_quat(rand_comp(u), rand_comp(u), rand_comp(u), rand_comp(u));
    end
    in_valid_i <= 1'b0;
    while (angle_sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);
    if (angle_sb.mismatches == 0 && angle_sb.pending_q.size() == 0)
      $display("** quaternion_to_euler_core: PASSED **");
    else
      $display("** quaternion_to_euler_core: FAILED **");
    $finish;
  end
endmodule
